### design/sparse_page_memory_defines.svh
// assertion macros of the sparse page memory top level
`ifndef SPARSE_PAGE_MEMORY_DEFINES_SVH
`define SPARSE_PAGE_MEMORY_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sparse_page_memory: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sparse_page_memory: next-cycle check failed");

`endif

### design/spm_pkg.sv
// shared types and constants of the sparse page memory
package spm_pkg;

    // configuration register
    localparam int unsigned BUDGET_W = 19;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 19'd266240;

    // word layout
    localparam int unsigned DATA_W = 64;
    localparam int unsigned SIZE_W = 2;

    // access kinds
    localparam logic ACTION_READ  = 1'b0;
    localparam logic ACTION_WRITE = 1'b1;

    // access width codes
    localparam logic [SIZE_W-1:0] SIZE_1B = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_2B = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_4B = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_8B = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MATCH,
        S_LOOKUP,
        S_ACCESS
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear;    // zero one data word of the clearing pass
        logic capture;  // take the input word
        logic match;    // compare all tags, register hit vector
        logic lookup;   // pick slot, allocate, issue data read
        logic finish;   // merge, write back, load result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;  // clearing pass at last word
        logic out_free;    // result register can take a word
    } t_status;

endpackage

### design/spm_ram.sv
// generic simple dual-port ram with registered read
module spm_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 32768
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/spm_ctrl.sv
// sequencer of the sparse page memory: clearing pass and per-access steps
module spm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  spm_pkg::t_status i_status,
    output logic             o_in_ready,
    output spm_pkg::t_cmd    o_cmd
);

    spm_pkg::t_state r_state;
    spm_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spm_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spm_pkg::S_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = spm_pkg::S_IDLE;
                end
            end
            spm_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = spm_pkg::S_MATCH;
                end
            end
            spm_pkg::S_MATCH: begin
                n_state = spm_pkg::S_LOOKUP;
            end
            spm_pkg::S_LOOKUP: begin
                n_state = spm_pkg::S_ACCESS;
            end
            spm_pkg::S_ACCESS: begin
                if (i_status.out_free) begin
                    n_state = spm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spm_pkg::S_CLEAR;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            spm_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            spm_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_valid;
            end
            spm_pkg::S_MATCH: begin
                o_cmd.match = 1'b1;
            end
            spm_pkg::S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
            end
            spm_pkg::S_ACCESS: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### design/spm_datapath.sv
// datapath of the sparse page memory: tags, page data ram, merge and result register
module spm_datapath #(
    parameter int unsigned MAX_PAGES  = 64,
    parameter int unsigned PAGE_BYTES = 4096,
    parameter int unsigned ADDR_BITS  = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  spm_pkg::t_cmd                  i_cmd,
    output spm_pkg::t_status               o_status,
    input  logic                           i_cfg_wr_en,
    input  logic [spm_pkg::BUDGET_W-1:0]   i_cfg_wr_data,
    input  logic                           i_action,
    input  logic [ADDR_BITS-1:0]           i_address,
    input  logic [spm_pkg::SIZE_W-1:0]     i_size_code,
    input  logic [spm_pkg::DATA_W-1:0]     i_write_data,
    input  logic                           i_ready,
    output logic                           o_valid,
    output logic [spm_pkg::DATA_W-1:0]     o_read_data,
    output logic                           o_page_present,
    output logic                           o_write_dropped
);

    localparam int unsigned OFF_W     = $clog2(PAGE_BYTES);
    localparam int unsigned TAG_W     = ADDR_BITS - OFF_W;
    localparam int unsigned WORD_W    = OFF_W - 3;
    localparam int unsigned SLOT_W    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int unsigned CNT_W     = $clog2(MAX_PAGES + 1);
    localparam int unsigned RAM_DEPTH = MAX_PAGES * (PAGE_BYTES / 8);
    localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH > 1 ? RAM_DEPTH : 2);
    localparam int unsigned FULL_AW   = SLOT_W + WORD_W;
    localparam int unsigned NEED_W    = CNT_W + OFF_W;
    localparam int unsigned CMP_W     =
        (NEED_W > spm_pkg::BUDGET_W) ? NEED_W : spm_pkg::BUDGET_W;
    localparam int unsigned DW        = spm_pkg::DATA_W;

    // lane mask for an access width
    function automatic logic [DW-1:0] lane_mask(input logic [spm_pkg::SIZE_W-1:0] size);
        logic [DW-1:0] m;
        m = '0;
        case (size)
            spm_pkg::SIZE_1B: m = {{(DW-8){1'b0}}, {8{1'b1}}};
            spm_pkg::SIZE_2B: m = {{(DW-16){1'b0}}, {16{1'b1}}};
            spm_pkg::SIZE_4B: m = {{(DW-32){1'b0}}, {32{1'b1}}};
            spm_pkg::SIZE_8B: m = '1;
            default:          m = '1;
        endcase
        return m;
    endfunction

    // budget register
    logic [spm_pkg::BUDGET_W-1:0] r_budget;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= spm_pkg::BUDGET_RESET;
        end else if (i_cfg_wr_en) begin
            r_budget <= i_cfg_wr_data;
        end
    end

    // captured access word
    logic                       r_write;
    logic [ADDR_BITS-1:0]       r_addr;
    logic [spm_pkg::SIZE_W-1:0] r_size;
    logic [DW-1:0]              r_wdata;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_write <= (i_action == spm_pkg::ACTION_WRITE);
            r_addr  <= i_address;
            r_size  <= i_size_code;
            r_wdata <= i_write_data;
        end
    end

    // address fields, access forced to natural alignment
    logic [TAG_W-1:0]  w_page;
    logic [WORD_W-1:0] w_word;
    logic [2:0]        w_lane;
    logic [5:0]        w_shift;
    logic [DW-1:0]     w_mask;
    assign w_page = r_addr[ADDR_BITS-1:OFF_W];
    assign w_word = r_addr[OFF_W-1:3];
    always_comb begin
        w_lane = r_addr[2:0];
        case (r_size)
            spm_pkg::SIZE_1B: w_lane = r_addr[2:0];
            spm_pkg::SIZE_2B: w_lane = {r_addr[2:1], 1'b0};
            spm_pkg::SIZE_4B: w_lane = {r_addr[2], 2'b00};
            spm_pkg::SIZE_8B: w_lane = 3'b000;
            default:          w_lane = 3'b000;
        endcase
    end
    assign w_shift = {w_lane, 3'b000};
    assign w_mask  = lane_mask(r_size);

    // tag store, slots fill in order
    logic [TAG_W-1:0]     r_tag [MAX_PAGES];
    logic [MAX_PAGES-1:0] r_slot_valid;
    logic [CNT_W-1:0]     r_used;
    logic [MAX_PAGES-1:0] r_hit;

    // parallel tag compare
    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            for (int i = 0; i < MAX_PAGES; i++) begin
                r_hit[i] <= r_slot_valid[i] && (r_tag[i] == w_page);
            end
        end
    end

    // hit encode; tags are unique so the hit vector is one-hot or empty
    logic [SLOT_W-1:0] w_hit_slot;
    logic              w_hit_any;
    always_comb begin
        w_hit_slot = '0;
        for (int i = 0; i < MAX_PAGES; i++) begin
            if (r_hit[i]) begin
                w_hit_slot = w_hit_slot | SLOT_W'(i);
            end
        end
    end
    assign w_hit_any = |r_hit;

    // allocation check: free slot, nonzero data and budget left
    logic [CMP_W-1:0]  w_need;
    logic              w_alloc;
    logic [SLOT_W-1:0] w_slot;
    assign w_need  = (CMP_W'(r_used) + CMP_W'(1)) << OFF_W;
    assign w_alloc = r_write && !w_hit_any && (|r_wdata) &&
                     (r_used < CNT_W'(MAX_PAGES)) &&
                     (w_need < CMP_W'(r_budget));
    assign w_slot  = w_hit_any ? w_hit_slot : SLOT_W'(r_used);

    // tag and fill count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_used       <= '0;
        end else if (i_cmd.lookup && w_alloc) begin
            r_slot_valid[SLOT_W'(r_used)] <= 1'b1;
            r_used                        <= r_used + CNT_W'(1);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup && w_alloc) begin
            r_tag[SLOT_W'(r_used)] <= w_page;
        end
    end

    // slot and presence held for the access step
    logic [SLOT_W-1:0] r_slot;
    logic              r_present;
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_slot    <= w_slot;
            r_present <= w_hit_any || w_alloc;
        end
    end

    // clearing pass counter
    logic [RAM_AW-1:0] r_clr_cnt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + RAM_AW'(1);
        end
    end

    // page data ram
    logic [FULL_AW-1:0] w_raddr_full;
    logic [FULL_AW-1:0] w_waddr_full;
    logic               w_ram_we;
    logic [RAM_AW-1:0]  w_ram_waddr;
    logic [DW-1:0]      w_ram_wdata;
    logic [DW-1:0]      w_ram_rdata;
    logic [DW-1:0]      w_merged;
    assign w_raddr_full = {w_slot, w_word};
    assign w_waddr_full = {r_slot, w_word};
    assign w_merged = (w_ram_rdata & ~(w_mask << w_shift)) | ((r_wdata & w_mask) << w_shift);
    assign w_ram_we    = i_cmd.clear || (i_cmd.finish && r_write && r_present);
    assign w_ram_waddr = i_cmd.clear ? r_clr_cnt : w_waddr_full[RAM_AW-1:0];
    assign w_ram_wdata = i_cmd.clear ? '0 : w_merged;

    spm_ram #(
        .WIDTH (DW),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (i_cmd.lookup),
        .i_raddr (w_raddr_full[RAM_AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // result register
    logic          r_out_valid;
    logic [DW-1:0] r_out_data;
    logic          r_out_present;
    logic          r_out_dropped;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data    <= (!r_write && r_present) ?
                             ((w_ram_rdata >> w_shift) & w_mask) : '0;
            r_out_present <= r_present;
            r_out_dropped <= r_write && !r_present;
        end
    end

    // status
    assign o_status.clear_last = (r_clr_cnt == RAM_AW'(RAM_DEPTH - 1));
    assign o_status.out_free   = !r_out_valid || i_ready;

    assign o_valid         = r_out_valid;
    assign o_read_data     = r_out_data;
    assign o_page_present  = r_out_present;
    assign o_write_dropped = r_out_dropped;

endmodule

### design/sparse_page_memory.sv
// top level of the sparse page memory
// A sparse byte address space backed by MAX_PAGES pages of PAGE_BYTES bytes, allocated in
// order on the first nonzero write to a page while the byte budget allows. Each access goes
// through capture, tag compare, slot pick with data read, and merge and write back before
// the next is accepted; the last step waits while the previous result word is still unread.
// The steps follow the registered tag compare and the registered read of the data ram, which
// has one write and one read port. The result word appears the cycle after write back. After
// reset a clearing pass zeroes all MAX_PAGES*PAGE_BYTES/8 data ram words (32768 at default
// sizes), during which no access word is taken; budget writes are accepted at any time.
`include "sparse_page_memory_defines.svh"

module sparse_page_memory #(
    parameter int unsigned MAX_PAGES  = 64,
    parameter int unsigned PAGE_BYTES = 4096,
    parameter int unsigned ADDR_BITS  = 48
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [spm_pkg::BUDGET_W-1:0] i_cfg_wr_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_action,
    input  logic [ADDR_BITS-1:0]         i_address,
    input  logic [spm_pkg::SIZE_W-1:0]   i_size_code,
    input  logic [spm_pkg::DATA_W-1:0]   i_write_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [spm_pkg::DATA_W-1:0]   o_read_data,
    output logic                         o_page_present,
    output logic                         o_write_dropped
);

    spm_pkg::t_cmd    w_cmd;
    spm_pkg::t_status w_status;

    // sequencer
    spm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_status   (w_status),
        .o_in_ready (o_ready),
        .o_cmd      (w_cmd)
    );

    // datapath
    spm_datapath #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_action        (i_action),
        .i_address       (i_address),
        .i_size_code     (i_size_code),
        .i_write_data    (i_write_data),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_read_data     (o_read_data),
        .o_page_present  (o_page_present),
        .o_write_dropped (o_write_dropped)
    );

    // checks
    `SPM_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, w_cmd.clear, !o_ready)
    `SPM_ASSERT_NOW(a_drop_not_present, i_clk, i_rst_n, o_valid && o_write_dropped,
                    !o_page_present && (o_read_data == '0))
    `SPM_ASSERT_NEXT(a_finish_loads_result, i_clk, i_rst_n, w_cmd.finish, o_valid)

endmodule
